FILE: rtl/csw_pkg.sv
// Shared types, codes and constants of the text console cell writer.
`timescale 1ns / 1ps

package csw_pkg;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ADDR_W  = 11;
  localparam int LOC_W   = 11;
  localparam int CELL_W  = 16;

  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 8;

  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_LIMIT = 8'h80;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } csw_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } csw_state_e;

  typedef struct packed {
    logic put;
    logic clear;
  } cur_cmd_t;

  typedef struct packed {
    logic store;
    logic overflow;
  } cur_stat_t;

  typedef struct packed {
    logic last;
    logic we;
    logic blank;
  } sweep_stat_t;

endpackage

FILE: rtl/csw_screen_mem.sv
// Screen cell memory: one write port, one registered read port.
`timescale 1ns / 1ps

module csw_screen_mem #(
  parameter int DEPTH = csw_pkg::DEF_COLUMNS * csw_pkg::DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [csw_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [csw_pkg::CELL_W-1:0] rdata_o
);
  import csw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/csw_cursor.sv
// Cursor registers and the put-character cursor arithmetic.
`timescale 1ns / 1ps

module csw_cursor #(
  parameter int COLUMNS  = csw_pkg::DEF_COLUMNS,
  parameter int ROWS     = csw_pkg::DEF_ROWS,
  parameter int TAB_STOP = csw_pkg::DEF_TAB_STOP,
  parameter int AW       = $clog2(COLUMNS * ROWS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csw_pkg::cur_cmd_t          cmd_i,
  input  logic [csw_pkg::CHAR_W-1:0] char_code_i,
  output csw_pkg::cur_stat_t         stat_o,
  output logic [AW-1:0]              index_o
);
  import csw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int TW = $clog2(TAB_STOP);
  localparam int NW = $clog2(COLUMNS + TAB_STOP);

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [TW-1:0] ph_q;

  logic [NW-1:0] ncol;
  logic [RW:0]   nrow;
  logic [TW-1:0] nph;
  logic          store;
  logic          overflow;

  always_comb begin
    ncol  = NW'(col_q);
    nrow  = (RW+1)'(row_q);
    nph   = ph_q;
    store = 1'b0;
    unique case (char_code_i)
      CODE_BS: begin
        if (col_q != '0) begin
          ncol = NW'(col_q) - NW'(1);
          nph  = (ph_q == '0) ? TW'(TAB_STOP - 1) : ph_q - TW'(1);
        end
      end
      CODE_TAB: begin
        ncol = NW'(col_q) + NW'(TAB_STOP) - NW'(ph_q);
        nph  = '0;
      end
      CODE_CR: begin
        ncol = '0;
        nph  = '0;
      end
      CODE_LF: begin
        ncol = '0;
        nph  = '0;
        nrow = nrow + (RW+1)'(1);
      end
      default: begin
        if (char_code_i >= CODE_SPACE && char_code_i < CODE_LIMIT) begin
          store = 1'b1;
          ncol  = NW'(col_q) + NW'(1);
          nph   = (ph_q == TW'(TAB_STOP - 1)) ? '0 : ph_q + TW'(1);
        end
      end
    endcase
    if (ncol >= NW'(COLUMNS)) begin
      ncol = '0;
      nph  = '0;
      nrow = nrow + (RW+1)'(1);
    end
    overflow = (nrow >= (RW+1)'(ROWS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ph_q  <= '0;
    end else if (cmd_i.clear) begin
      col_q <= '0;
      row_q <= '0;
      ph_q  <= '0;
    end else if (cmd_i.put) begin
      col_q <= CW'(ncol);
      row_q <= overflow ? RW'(ROWS - 1) : RW'(nrow);
      ph_q  <= nph;
    end
  end

  assign stat_o.store    = store;
  assign stat_o.overflow = overflow;
  assign index_o         = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

endmodule

FILE: rtl/csw_sweep.sv
// Sweep sequencer: walks every cell once for a scroll or a clear.
`timescale 1ns / 1ps

module csw_sweep #(
  parameter int COLUMNS = csw_pkg::DEF_COLUMNS,
  parameter int ROWS    = csw_pkg::DEF_ROWS,
  parameter int AW      = $clog2(COLUMNS * ROWS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 blank_all_i,
  output csw_pkg::sweep_stat_t stat_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o
);
  import csw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int KEEP  = (ROWS - 1) * COLUMNS;

  logic          run_q;
  logic          all_q;
  logic [AW-1:0] cnt_q;
  logic          pend_q;
  logic          pend_blank_q;
  logic [AW-1:0] pend_addr_q;

  logic          issue_blank;
  logic          last;
  logic [AW:0]   src;

  always_comb begin
    issue_blank = all_q || (cnt_q >= AW'(KEEP));
    src         = (AW+1)'(cnt_q) + (AW+1)'(COLUMNS);
    rd_addr_o   = issue_blank ? '0 : AW'(src);
    last        = run_q && (cnt_q == AW'(CELLS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      all_q  <= 1'b0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= run_q;
      if (start_i) begin
        run_q <= 1'b1;
        all_q <= blank_all_i;
        cnt_q <= '0;
      end else if (run_q) begin
        if (last) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_blank_q <= issue_blank;
    pend_addr_q  <= cnt_q;
  end

  assign stat_o.last  = last;
  assign stat_o.we    = pend_q;
  assign stat_o.blank = pend_blank_q;
  assign wr_addr_o    = pend_addr_q;

endmodule

FILE: rtl/text_console_cell_writer.sv
// Text console cell writer: top level with command sequencer and result register.
//
// Input channel (in_valid_i / in_ready_o) carries one command: put a
// character, clear the screen or read one cell. Output channel
// (out_valid_o / out_ready_i) returns one result per command: the cursor
// location after the command, a scroll flag and the cell read.
// One command at a time; in_ready_o is high only while the sequencer idles.
// Path from transfer in to out_valid_o:
//   put without scroll, unused command: straight to the final step
//   read: through the read state for the registered memory read
//   put that scrolls, clear: through the sweep state, run by the
//   sweep unit that copies or blanks one cell per memory port cycle.
// The next command is taken in the cycle after the result register loads,
// even while that result still waits for out_ready_i; a further command
// then waits in the final step until the result register frees up.
// Reset clears the cursor and both channels; screen memory is not cleared
// and holds unknown cells until a clear command or writes fill it.
`timescale 1ns / 1ps

module text_console_cell_writer #(
  parameter int COLUMNS  = csw_pkg::DEF_COLUMNS,
  parameter int ROWS     = csw_pkg::DEF_ROWS,
  parameter int TAB_STOP = csw_pkg::DEF_TAB_STOP
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [csw_pkg::CMD_W-1:0]   command_i,
  input  logic [csw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [csw_pkg::COLOR_W-1:0] back_color_i,
  input  logic [csw_pkg::COLOR_W-1:0] fore_color_i,
  input  logic [csw_pkg::ADDR_W-1:0]  cell_address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csw_pkg::LOC_W-1:0]   cursor_pos_o,
  output logic                        scrolled_o,
  output logic [csw_pkg::CELL_W-1:0]  cell_data_o
);
  import csw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  csw_state_e        state_q, state_d;
  logic              scr_q, scr_d;
  logic [CELL_W-1:0] data_q, data_d;
  logic              rng_q, rng_d;
  logic              out_valid_q, out_valid_d;
  logic [LOC_W-1:0]  out_loc_q;
  logic              out_scr_q;
  logic [CELL_W-1:0] out_data_q;

  logic              accept;
  logic              in_range;
  logic              out_load;
  logic              store_we;
  logic              sw_start;
  logic              sw_blank_all;
  cur_cmd_t          cur_cmd;
  cur_stat_t         cur_stat;
  sweep_stat_t       sw_stat;
  logic [AW-1:0]     cur_index;
  logic [AW-1:0]     sw_rd_addr;
  logic [AW-1:0]     sw_wr_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (32'(cell_address_i) < 32'(CELLS));

  always_comb begin
    state_d      = state_q;
    scr_d        = scr_q;
    data_d       = data_q;
    rng_d        = rng_q;
    cur_cmd      = '0;
    sw_start     = 1'b0;
    sw_blank_all = 1'b0;
    store_we     = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scr_d  = 1'b0;
          data_d = '0;
          rng_d  = in_range;
          unique case (csw_cmd_e'(command_i))
            CMD_PUT: begin
              cur_cmd.put = 1'b1;
              store_we    = cur_stat.store;
              if (cur_stat.overflow) begin
                sw_start = 1'b1;
                scr_d    = 1'b1;
                state_d  = ST_SWEEP;
              end else begin
                state_d = ST_DONE;
              end
            end
            CMD_CLEAR: begin
              cur_cmd.clear = 1'b1;
              sw_start      = 1'b1;
              sw_blank_all  = 1'b1;
              state_d       = ST_SWEEP;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        data_d  = rng_q ? mem_rdata : '0;
        state_d = ST_DONE;
      end
      ST_SWEEP: begin
        if (sw_stat.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scr_q  <= scr_d;
    data_q <= data_d;
    rng_q  <= rng_d;
    if (out_load) begin
      out_loc_q  <= LOC_W'(cur_index);
      out_scr_q  <= scr_q;
      out_data_q <= data_q;
    end
  end

  always_comb begin
    mem_we    = sw_stat.we || store_we;
    mem_waddr = sw_stat.we ? sw_wr_addr : cur_index;
    mem_wdata = sw_stat.we ? (sw_stat.blank ? BLANK_CELL : mem_rdata)
                           : {back_color_i, fore_color_i, char_code_i};
    if (state_q == ST_SWEEP) begin
      mem_raddr = sw_rd_addr;
    end else begin
      mem_raddr = in_range ? AW'(cell_address_i) : '0;
    end
  end

  csw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .AW       (AW)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cur_cmd),
    .char_code_i (char_code_i),
    .stat_o      (cur_stat),
    .index_o     (cur_index)
  );

  csw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_sweep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (sw_start),
    .blank_all_i (sw_blank_all),
    .stat_o      (sw_stat),
    .rd_addr_o   (sw_rd_addr),
    .wr_addr_o   (sw_wr_addr)
  );

  csw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_loc_q;
  assign scrolled_o   = out_scr_q;
  assign cell_data_o  = out_data_q;

endmodule

FILE: rtl/csw_checker.sv
// Port-level checks of the text console cell writer, bound to the top level.
`timescale 1ns / 1ps

module csw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [csw_pkg::LOC_W-1:0]   cursor_pos_o,
  input logic                        scrolled_o,
  input logic [csw_pkg::CELL_W-1:0]  cell_data_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready after a transfer");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("ready dropped with no transfer");

  a_scroll_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cell_data_o == '0)
    else $error("scrolled result carries cell data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_pos_o)
      && $stable(scrolled_o) && $stable(cell_data_o))
    else $error("stalled result changed");

endmodule

bind text_console_cell_writer csw_checker u_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the text console cell writer: directed table, then random commands.
`timescale 1ns / 1ps

module tb_top;
  import csw_pkg::*;

  localparam int COLUMNS      = DEF_COLUMNS;
  localparam int ROWS         = DEF_ROWS;
  localparam int TAB_STOP     = DEF_TAB_STOP;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS = 240;
  localparam int ROW_COUNT    = 25;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * CELLS + 100;
  localparam int CYCLE_LIMIT  = 5_000_000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [LOC_W-1:0]  location;
    logic              scrolled;
    logic [CELL_W-1:0] data;
  } console_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  code;
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         reps;
    logic               typed;
    console_result_t    want;
  } stim_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i      = '0;
  logic [CHAR_W-1:0]  char_code_i    = '0;
  logic [COLOR_W-1:0] back_color_i   = '0;
  logic [COLOR_W-1:0] fore_color_i   = '0;
  logic [ADDR_W-1:0]  cell_address_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [LOC_W-1:0]   cursor_pos_o;
  logic               scrolled_o;
  logic [CELL_W-1:0]  cell_data_o;

  logic [CELL_W-1:0] screen_model [CELLS];
  int                cur_col = 0;
  int                cur_row = 0;

  console_result_t pending_results [$];
  console_result_t head_result;
  stim_row_t       directed_rows [ROW_COUNT];

  bit rx_hold     = 1'b0;
  bit quiet_phase = 1'b0;
  int failures        = 0;
  int commands_sent   = 0;
  int random_sent     = 0;
  int results_checked = 0;
  int scroll_count    = 0;
  int clear_count     = 0;
  int read_count      = 0;
  int cycle_count     = 0;

  text_console_cell_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .char_code_i   (char_code_i),
    .back_color_i  (back_color_i),
    .fore_color_i  (fore_color_i),
    .cell_address_i(cell_address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cursor_pos_o  (cursor_pos_o),
    .scrolled_o    (scrolled_o),
    .cell_data_o   (cell_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic console_result_t console_step(input logic [CMD_W-1:0] cmd,
                                                   input logic [CHAR_W-1:0] code,
                                                   input logic [COLOR_W-1:0] back,
                                                   input logic [COLOR_W-1:0] fore,
                                                   input logic [ADDR_W-1:0] addr);
    console_result_t res;
    res = '0;
    if (cmd == CMD_PUT) begin
      if (code == CODE_BS) begin
        if (cur_col > 0) cur_col--;
      end else if (code == CODE_TAB) begin
        cur_col = cur_col - (cur_col % TAB_STOP) + TAB_STOP;
      end else if (code == CODE_CR) begin
        cur_col = 0;
      end else if (code == CODE_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (code >= CODE_SPACE && code < CODE_LIMIT) begin
        screen_model[cur_row * COLUMNS + cur_col] = {back, fore, code};
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_row = ROWS - 1;
        res.scrolled = 1'b1;
        scroll_count++;
      end
    end else if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
      clear_count++;
    end else if (cmd == CMD_READ) begin
      if (addr < CELLS) res.data = screen_model[addr];
      read_count++;
    end
    res.location = LOC_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h",
                                            name, want, got));
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                              input logic [COLOR_W-1:0] back, input logic [COLOR_W-1:0] fore,
                              input logic [ADDR_W-1:0] addr, input logic typed,
                              input console_result_t want);
    console_result_t predicted;
    while (!quiet_phase && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    char_code_i    <= code;
    back_color_i   <= back;
    fore_color_i   <= fore;
    cell_address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = console_step(cmd, code, back, fore, addr);
    pending_results.push_back(typed ? want : predicted);
    commands_sent++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && (quiet_phase || $urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: location 0x%0h scrolled %0b data 0x%0h",
                               cursor_pos_o, scrolled_o, cell_data_o));
      end else begin
        head_result = pending_results.pop_front();
        check_field("cursor_pos", int'(head_result.location), int'(cursor_pos_o));
        check_field("scrolled", int'(head_result.scrolled), int'(scrolled_o));
        check_field("cell_data", int'(head_result.data), int'(cell_data_o));
        results_checked++;
      end
    end
  end

  // Hold off the receiver so the result register fills and the input stalls.
  initial begin
    wait (random_sent == 60);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  code;
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    logic [ADDR_W-1:0]  addr;
    int                 pick;
    int                 sel;

    directed_rows = '{
      '{CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 11'h7FF, 8'd1, 1'b1, '{11'd0, 1'b0, 16'h0000}},
      '{CMD_READ, 8'h00, 4'h0, 4'h0, 11'h7FF, 8'd1, 1'b1, '{11'd0, 1'b0, 16'h0000}},
      '{CMD_READ, 8'h00, 4'h0, 4'h0, 11'd2000, 8'd1, 1'b1, '{11'd0, 1'b0, 16'h0000}},
      '{CMD_PUT, 8'h41, 4'hF, 4'h0, 11'd0, 8'd1, 1'b1, '{11'd1, 1'b0, 16'h0000}},
      '{CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0, 8'd1, 1'b1, '{11'd1, 1'b0, 16'hF041}},
      '{CMD_PUT, CODE_BS, 4'h0, 4'h0, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, CODE_BS, 4'h0, 4'h0, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, 8'h7F, 4'h0, 4'hF, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, CODE_SPACE, 4'hA, 4'h5, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, 8'h80, 4'h1, 4'h1, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, 8'hFF, 4'hF, 4'hF, 11'h7FF, 8'd1, 1'b0, '0},
      '{CMD_PUT, 8'h00, 4'h0, 4'h0, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, 8'h1F, 4'h2, 4'h3, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, CODE_TAB, 4'h0, 4'h0, 11'd0, 8'd2, 1'b0, '0},
      '{CMD_PUT, 8'h61, 4'h3, 4'hC, 11'd0, 8'd3, 1'b0, '0},
      '{CMD_PUT, CODE_CR, 4'h0, 4'h0, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, CODE_LF, 4'h0, 4'h0, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0, 8'd1, 1'b1, '{11'd0, 1'b0, 16'h0000}},
      '{CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1999, 8'd1, 1'b1, '{11'd0, 1'b0, BLANK_CELL}},
      '{CMD_PUT, CODE_LF, 4'h0, 4'h0, 11'd0, 8'd24, 1'b0, '0},
      '{CMD_PUT, 8'h5A, 4'h1, 4'h2, 11'd0, 8'd1, 1'b0, '0},
      '{CMD_PUT, CODE_TAB, 4'h0, 4'h0, 11'd0, 8'd10, 1'b0, '0},
      '{CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1920, 8'd1, 1'b0, '0},
      '{CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1840, 8'd1, 1'b0, '0},
      '{CMD_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0, 8'd1, 1'b1, '{11'd0, 1'b0, 16'h0000}}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_command(directed_rows[r].cmd, directed_rows[r].code, directed_rows[r].back,
                     directed_rows[r].fore, directed_rows[r].addr, directed_rows[r].typed,
                     directed_rows[r].want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase <= (n >= 170 && n < 240);
      if (n == 150) begin
        // Drain the block completely before going on.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      pick = $urandom_range(99);
      cmd  = CMD_PUT;
      code = CHAR_W'($urandom_range(255));
      back = COLOR_W'($urandom_range(15));
      fore = COLOR_W'($urandom_range(15));
      addr = ADDR_W'($urandom_range(2047));
      if (pick < 50) begin
        code = CHAR_W'($urandom_range(32'h7F, 32'h20));
      end else if (pick < 60) begin
        code = CODE_LF;
      end else if (pick < 66) begin
        code = CODE_TAB;
      end else if (pick < 70) begin
        code = CODE_BS;
      end else if (pick < 73) begin
        code = CODE_CR;
      end else if (pick >= 77 && pick < 93) begin
        cmd = CMD_READ;
        sel = $urandom_range(9);
        if (sel < 2) addr = ADDR_W'($urandom_range(2047, CELLS));
        else if (sel < 5) addr = ADDR_W'(cur_row * COLUMNS + $urandom_range(COLUMNS - 1));
        else addr = ADDR_W'($urandom_range(CELLS - 1));
      end else if (pick >= 93 && pick < 97) begin
        cmd = CMD_UNUSED;
      end else if (pick >= 97) begin
        cmd = CMD_CLEAR;
      end
      send_command(cmd, code, back, fore, addr, 1'b0, '0);
      random_sent++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) note_failure("results still expected at end of run");

    $display("Sent %0d commands (%0d random), checked %0d results in %0d cycles.",
             commands_sent, random_sent, results_checked, cycle_count);
    $display("Covered %0d scrolls, %0d clears and %0d reads; %0d failures.",
             scroll_count, clear_count, read_count, failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
